/* hw/rtl/i2cmbe_pkg.sv */
// ----------------------------------------------------------------------------
// I2C master bit engine package
// Shared types, codes and the segment sequencing functions of the engine.
// ----------------------------------------------------------------------------
package i2cmbe_pkg;

   localparam int HOLD_COUNT_WIDTH_DEF = 16;
   localparam int HALF_PERIOD_WIDTH    = 16;
   localparam logic [HALF_PERIOD_WIDTH-1:0] HALF_PERIOD_RESET = 16'd250;

   localparam logic [4:0] STEP_IDLE = 5'd31;

   typedef enum logic [1:0] {
      CMD_START = 2'd0,
      CMD_STOP  = 2'd1,
      CMD_WRITE = 2'd2,
      CMD_READ  = 2'd3
   } cmd_type;

   // One queued word, already classified by the front end.
   typedef struct packed {
      logic       has_cmd;
      cmd_type    func;
      logic [7:0] shift_init;
      logic       send_ack;
      logic       sda_in;
   } item_type;

   typedef struct packed {
      logic       scl_out;
      logic       sda_out;
      logic       busy_res;
      logic       done_res;
      logic [7:0] rx_byte;
      logic       ack_error;
   } rsp_type;

   typedef struct packed {
      logic [4:0] step;
      cmd_type    cmd;
      logic [7:0] shift;
      logic       scl;
      logic       sda;
      logic       ack;
      logic       send_ack;
      logic [7:0] rx;
   } eng_state_type;

   function automatic logic [4:0] last_step(cmd_type c);
      logic [4:0] r;
      case (c)
         CMD_START: r = 5'd2;
         CMD_STOP:  r = 5'd3;
         CMD_WRITE: r = 5'd18;
         default:   r = 5'd19;
      endcase
      return r;
   endfunction

   // Levels that a segment starts with.
   function automatic eng_state_type enter_seg(eng_state_type st, logic [4:0] s);
      eng_state_type r;
      r = st;
      case (r.cmd)
         CMD_START: begin
            if (s == 5'd0) begin
               r.sda = 1'b1;
               r.scl = 1'b1;
            end else if (s == 5'd1) begin
               r.sda = 1'b0;
            end else begin
               r.scl = 1'b0;
            end
         end
         CMD_STOP: begin
            if (s == 5'd0) r.scl = 1'b0;
            else if (s == 5'd1) r.sda = 1'b0;
            else if (s == 5'd2) r.scl = 1'b1;
            else r.sda = 1'b1;
         end
         CMD_WRITE: begin
            if (s < 5'd16) begin
               if (!s[0]) begin
                  if (s != 5'd0) r.scl = 1'b0;
                  r.sda   = r.shift[7];
                  r.shift = {r.shift[6:0], 1'b0};
               end else begin
                  r.scl = 1'b1;
               end
            end else if (s == 5'd16) begin
               r.scl = 1'b0;
               r.sda = 1'b1;
            end else if (s == 5'd17) begin
               r.scl = 1'b1;
            end else begin
               r.scl = 1'b0;
            end
         end
         CMD_READ: begin
            if (s < 5'd16) begin
               r.scl = !s[0];
            end else if (s == 5'd16) begin
               r.scl = 1'b0;
            end else if (s == 5'd17) begin
               r.sda = !r.send_ack;
            end else if (s == 5'd18) begin
               r.scl = 1'b1;
            end else begin
               r.scl = 1'b0;
               if (r.send_ack) r.sda = 1'b1;
            end
         end
         default: r = st;
      endcase
      return r;
   endfunction

   // Sampling on the last tick of a segment.
   function automatic eng_state_type end_seg(eng_state_type st, logic [4:0] s,
                                             logic sda);
      eng_state_type r;
      r = st;
      if (r.cmd == CMD_WRITE && s == 5'd17) begin
         r.ack = sda;
      end else if (r.cmd == CMD_READ && s < 5'd16 && !s[0]) begin
         r.shift = {r.shift[6:0], sda};
      end else if (r.cmd == CMD_READ && s == 5'd15) begin
         r.rx = r.shift;
      end
      return r;
   endfunction

endpackage

/* hw/rtl/i2c_master_bit_engine.sv */
// ----------------------------------------------------------------------------
// I2C master bit engine
// Pin-level I2C master: start, stop, write byte and read byte sequences.
// ----------------------------------------------------------------------------
//   Channel  Direction  Handshake             Word
//   req_     in         req_valid/req_stall   one bus tick, optional command
//   rsp_     out        rsp_valid/rsp_stall   pin levels and status of a tick
//   csr_     in         csr_wr_en             half period in ticks
//
// One word is taken per cycle while req_stall is low. A word accepted is
// written into the queue, run from there by the sequencer, and its result is
// held in the output register until it is taken. A two-entry queue sits
// between the input side and the sequencer, so a stall on the result side
// reaches req_stall only once the queue is full. Reset clears the queue and
// the output register and returns the sequencer to idle with both lines
// released and the half period at 250.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine #(
   parameter int HOLD_COUNT_WIDTH = i2cmbe_pkg::HOLD_COUNT_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_cmd_valid,
   input  logic [1:0]  req_func,
   input  logic [7:0]  req_tx_byte,
   input  logic        req_send_ack,
   input  logic        req_sda_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_scl_out,
   output logic        rsp_sda_out,
   output logic        rsp_busy_res,
   output logic        rsp_done_res,
   output logic [7:0]  rsp_rx_byte,
   output logic        rsp_ack_error
);
   import i2cmbe_pkg::*;

   logic     item_valid;
   item_type item;
   logic     item_pop;
   rsp_type  rsp;

   i2cmbe_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_cmd_valid (req_cmd_valid),
      .req_func      (req_func),
      .req_tx_byte   (req_tx_byte),
      .req_send_ack  (req_send_ack),
      .req_sda_in    (req_sda_in),
      .item_valid    (item_valid),
      .item          (item),
      .item_pop      (item_pop)
   );

   i2cmbe_engine #(
      .HOLD_COUNT_WIDTH (HOLD_COUNT_WIDTH)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .item_valid  (item_valid),
      .item        (item),
      .item_pop    (item_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp         (rsp)
   );

   assign rsp_scl_out   = rsp.scl_out;
   assign rsp_sda_out   = rsp.sda_out;
   assign rsp_busy_res  = rsp.busy_res;
   assign rsp_done_res  = rsp.done_res;
   assign rsp_rx_byte   = rsp.rx_byte;
   assign rsp_ack_error = rsp.ack_error;

endmodule

/* hw/rtl/i2cmbe_front.sv */
// ----------------------------------------------------------------------------
// I2C master bit engine front end
// Accepts tick words, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module i2cmbe_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_cmd_valid,
   input  logic [1:0]            req_func,
   input  logic [7:0]            req_tx_byte,
   input  logic                  req_send_ack,
   input  logic                  req_sda_in,
   output logic                  item_valid,
   output i2cmbe_pkg::item_type  item,
   input  logic                  item_pop
);
   import i2cmbe_pkg::*;

   item_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   logic       pop;
   item_type   new_item;

   assign req_stall  = (count_ff == 2'd2);
   assign push       = req_valid && !req_stall;
   assign item_valid = (count_ff != 2'd0);
   assign pop        = item_pop && item_valid;
   assign item       = entry_ff[rd_ptr_ff];

   always_comb begin
      new_item.has_cmd    = req_cmd_valid;
      new_item.func       = cmd_type'(req_func);
      new_item.shift_init = (cmd_type'(req_func) == CMD_WRITE) ? req_tx_byte : 8'd0;
      new_item.send_ack   = req_send_ack;
      new_item.sda_in     = req_sda_in;
   end

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

/* hw/rtl/i2cmbe_engine.sv */
// ----------------------------------------------------------------------------
// I2C master bit engine sequencer
// Steps through the SCL/SDA segment sequences, one queued word per tick.
// ----------------------------------------------------------------------------
module i2cmbe_engine #(
   parameter int HOLD_COUNT_WIDTH = i2cmbe_pkg::HOLD_COUNT_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [15:0]           csr_wr_data,
   input  logic                  item_valid,
   input  i2cmbe_pkg::item_type  item,
   output logic                  item_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output i2cmbe_pkg::rsp_type   rsp
);
   import i2cmbe_pkg::*;

   logic [HALF_PERIOD_WIDTH-1:0]                  half_period_ff;
   logic [HOLD_COUNT_WIDTH+HALF_PERIOD_WIDTH-1:0] period_ext;
   logic [HOLD_COUNT_WIDTH-1:0]                   period_cut;
   logic [HOLD_COUNT_WIDTH-1:0]                   hold_load;
   logic [HOLD_COUNT_WIDTH-1:0]                   hold_ff, hold_in;
   eng_state_type                                 st_ff, st_in;
   logic                                          rsp_valid_ff;
   rsp_type                                       rsp_ff, rsp_in;
   logic                                          fire;

   // The period is zero-extended or truncated to the counter, and zero acts as one.
   assign period_ext = {{HOLD_COUNT_WIDTH{1'b0}}, half_period_ff};
   assign period_cut = period_ext[HOLD_COUNT_WIDTH-1:0];
   assign hold_load  = (period_cut == '0) ? HOLD_COUNT_WIDTH'(1) : period_cut;

   assign fire      = item_valid && (!rsp_valid_ff || !rsp_stall);
   assign item_pop  = fire;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   always_comb begin
      st_in            = st_ff;
      hold_in          = hold_ff;
      rsp_in.busy_res  = 1'b0;
      rsp_in.done_res  = 1'b0;
      if (st_in.step == STEP_IDLE && item.has_cmd) begin
         st_in.cmd      = item.func;
         st_in.send_ack = item.send_ack;
         st_in.shift    = item.shift_init;
         st_in.step     = 5'd0;
         st_in          = enter_seg(st_in, 5'd0);
         hold_in        = hold_load;
      end
      rsp_in.scl_out = st_in.scl;
      rsp_in.sda_out = st_in.sda;
      if (st_in.step != STEP_IDLE) begin
         rsp_in.busy_res = 1'b1;
         if (hold_in != '0) hold_in = hold_in - HOLD_COUNT_WIDTH'(1);
         if (hold_in == '0) begin
            st_in = end_seg(st_in, st_in.step, item.sda_in);
            if (st_in.step >= last_step(st_in.cmd)) begin
               rsp_in.done_res = 1'b1;
               st_in.step      = STEP_IDLE;
            end else begin
               st_in.step = st_in.step + 5'd1;
               st_in      = enter_seg(st_in, st_in.step);
               hold_in    = hold_load;
            end
         end
      end
      rsp_in.rx_byte   = st_in.rx;
      rsp_in.ack_error = st_in.ack;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff <= HALF_PERIOD_RESET;
      end else if (csr_wr_en) begin
         half_period_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff.step     <= STEP_IDLE;
         st_ff.cmd      <= CMD_START;
         st_ff.shift    <= 8'd0;
         st_ff.scl      <= 1'b1;
         st_ff.sda      <= 1'b1;
         st_ff.ack      <= 1'b0;
         st_ff.send_ack <= 1'b0;
         st_ff.rx       <= 8'd0;
         hold_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (fire) begin
            st_ff   <= st_in;
            hold_ff <= hold_in;
         end
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

/* hw/rtl/i2cmbe_checker.sv */
// ----------------------------------------------------------------------------
// I2C master bit engine checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module i2cmbe_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_scl_out,
   input logic        rsp_sda_out,
   input logic        rsp_busy_res,
   input logic        rsp_done_res,
   input logic [7:0]  rsp_rx_byte,
   input logic        rsp_ack_error
);

   // A stalled result word stays valid and unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_scl_out) &&
      $stable(rsp_sda_out) && $stable(rsp_busy_res) && $stable(rsp_done_res) &&
      $stable(rsp_rx_byte) && $stable(rsp_ack_error))
      else $error("stalled result word changed");

   // The last tick of a sequence is still a busy tick.
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> rsp_busy_res)
      else $error("done without busy");

   // Reset empties the output register and the queue.
   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && !req_stall)
      else $error("result or stall present after reset");

   // With no word accepted and no result word waiting throughout the antecedent,
   // the queue is empty, so no result word can appear next.
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && !(req_valid && !req_stall) ##1
      !rsp_valid && !(req_valid && !req_stall) |=> !rsp_valid)
      else $error("result word without a pending tick");

endmodule

bind i2c_master_bit_engine i2cmbe_checker u_checker (.*);

/* bench/i2c_bus_tick_checker.sv */
// ----------------------------------------------------------------------------
// I2C bus tick checker
// Watches the tick and result channels of the I2C master bit engine, runs
// its own model of the segment sequencer on every accepted tick word and
// compares each result word field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module i2c_bus_tick_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_cmd_valid,
   input  logic [1:0]  req_func,
   input  logic [7:0]  req_tx_byte,
   input  logic        req_send_ack,
   input  logic        req_sda_in,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        rsp_scl_out,
   input  logic        rsp_sda_out,
   input  logic        rsp_busy_res,
   input  logic        rsp_done_res,
   input  logic [7:0]  rsp_rx_byte,
   input  logic        rsp_ack_error,
   output int          mismatches,
   output int          pending_ticks,
   output int          words_checked,
   output int          sequences_done
);
   import i2cmbe_pkg::*;

   logic [15:0] half_ticks;
   logic [4:0]  seg;
   cmd_type     op;
   logic [7:0]  shreg;
   logic [15:0] hold_left;
   logic        scl_lvl;
   logic        sda_lvl;
   logic        ack_seen;
   logic        ack_to_send;
   logic [7:0]  rx_last;

   rsp_type expected_ticks[$];
   int      n_err;
   int      n_words;
   int      n_seq;

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch at word %0d: %s", $time, n_words, msg);
      n_err++;
   endtask

   function automatic logic [4:0] final_segment(cmd_type c);
      case (c)
         CMD_START: return 5'd2;
         CMD_STOP:  return 5'd3;
         CMD_WRITE: return 5'd18;
         default:   return 5'd19;
      endcase
   endfunction

   // Levels driven at the start of segment s, then the hold time reloads.
   task automatic open_segment(input logic [4:0] s);
      case (op)
         CMD_START: begin
            if (s == 5'd0) begin
               sda_lvl = 1'b1;
               scl_lvl = 1'b1;
            end else if (s == 5'd1) begin
               sda_lvl = 1'b0;
            end else begin
               scl_lvl = 1'b0;
            end
         end
         CMD_STOP: begin
            if (s == 5'd0) scl_lvl = 1'b0;
            else if (s == 5'd1) sda_lvl = 1'b0;
            else if (s == 5'd2) scl_lvl = 1'b1;
            else sda_lvl = 1'b1;
         end
         CMD_WRITE: begin
            if (s < 5'd16) begin
               if (s[0] == 1'b0) begin
                  // The first data bit leaves SCL where it was.
                  if (s != 5'd0) scl_lvl = 1'b0;
                  sda_lvl = shreg[7];
                  shreg   = {shreg[6:0], 1'b0};
               end else begin
                  scl_lvl = 1'b1;
               end
            end else if (s == 5'd16) begin
               scl_lvl = 1'b0;
               sda_lvl = 1'b1;
            end else if (s == 5'd17) begin
               scl_lvl = 1'b1;
            end else begin
               scl_lvl = 1'b0;
            end
         end
         default: begin
            if (s < 5'd16) begin
               scl_lvl = ~s[0];
            end else if (s == 5'd16) begin
               scl_lvl = 1'b0;
            end else if (s == 5'd17) begin
               sda_lvl = ~ack_to_send;
            end else if (s == 5'd18) begin
               scl_lvl = 1'b1;
            end else begin
               scl_lvl = 1'b0;
               if (ack_to_send) sda_lvl = 1'b1;
            end
         end
      endcase
      hold_left = (half_ticks == 16'd0) ? 16'd1 : half_ticks;
   endtask

   // SDA is sampled on the last tick of a segment.
   task automatic close_segment(input logic [4:0] s, input logic sda);
      if (op == CMD_WRITE && s == 5'd17) begin
         ack_seen = sda;
      end else if (op == CMD_READ && s < 5'd16 && s[0] == 1'b0) begin
         shreg = {shreg[6:0], sda};
      end else if (op == CMD_READ && s == 5'd15) begin
         rx_last = shreg;
      end
   endtask

   task automatic predict_tick(input logic cv, input logic [1:0] fn, input logic [7:0] tx,
                               input logic am, input logic sda, output rsp_type r);
      r = '0;
      if (seg == STEP_IDLE && cv) begin
         op          = cmd_type'(fn);
         ack_to_send = am;
         shreg       = (op == CMD_WRITE) ? tx : 8'h00;
         seg         = 5'd0;
         open_segment(5'd0);
      end
      r.scl_out = scl_lvl;
      r.sda_out = sda_lvl;
      if (seg != STEP_IDLE) begin
         r.busy_res = 1'b1;
         if (hold_left != 16'd0) hold_left = hold_left - 16'd1;
         if (hold_left == 16'd0) begin
            close_segment(seg, sda);
            if (seg >= final_segment(op)) begin
               r.done_res = 1'b1;
               seg        = STEP_IDLE;
            end else begin
               seg = seg + 5'd1;
               open_segment(seg);
            end
         end
      end
      r.rx_byte   = rx_last;
      r.ack_error = ack_seen;
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      rsp_type got;
      if (reset) begin
         half_ticks  = HALF_PERIOD_RESET;
         seg         = STEP_IDLE;
         op          = CMD_START;
         shreg       = 8'h00;
         hold_left   = 16'd0;
         scl_lvl     = 1'b1;
         sda_lvl     = 1'b1;
         ack_seen    = 1'b0;
         ack_to_send = 1'b0;
         rx_last     = 8'h00;
         expected_ticks.delete();
      end else begin
         if (csr_wr_en) half_ticks = csr_wr_data;
         if (req_valid && !req_stall) begin
            predict_tick(req_cmd_valid, req_func, req_tx_byte, req_send_ack, req_sda_in, want);
            expected_ticks.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            got.scl_out   = rsp_scl_out;
            got.sda_out   = rsp_sda_out;
            got.busy_res  = rsp_busy_res;
            got.done_res  = rsp_done_res;
            got.rx_byte   = rsp_rx_byte;
            got.ack_error = rsp_ack_error;
            if (expected_ticks.size() == 0) begin
               report_mismatch("result word arrived with nothing expected");
            end else begin
               want = expected_ticks.pop_front();
               if (got.scl_out !== want.scl_out)
                  report_mismatch($sformatf("scl_out %b, expected %b", got.scl_out, want.scl_out));
               if (got.sda_out !== want.sda_out)
                  report_mismatch($sformatf("sda_out %b, expected %b", got.sda_out, want.sda_out));
               if (got.busy_res !== want.busy_res)
                  report_mismatch($sformatf("busy_res %b, expected %b",
                                            got.busy_res, want.busy_res));
               if (got.done_res !== want.done_res)
                  report_mismatch($sformatf("done_res %b, expected %b",
                                            got.done_res, want.done_res));
               if (got.rx_byte !== want.rx_byte)
                  report_mismatch($sformatf("rx_byte 0x%h, expected 0x%h",
                                            got.rx_byte, want.rx_byte));
               if (got.ack_error !== want.ack_error)
                  report_mismatch($sformatf("ack_error %b, expected %b",
                                            got.ack_error, want.ack_error));
               if (want.done_res) n_seq++;
            end
            n_words++;
         end
      end
      mismatches     <= n_err;
      pending_ticks  <= expected_ticks.size();
      words_checked  <= n_words;
      sequences_done <= n_seq;
   end

endmodule

/* bench/tb_i2c_master_bit_engine.sv */
// ----------------------------------------------------------------------------
// I2C master bit engine testbench
// Drives bus tick words with random gaps and random result stalls: first the
// reset half period, then directed start, stop, write and read sequences at a
// zero half period with fixed and random SDA and commands issued while busy,
// then random ticks over several half periods and a short look at the widest
// setting. A checker predicts every word.
// ----------------------------------------------------------------------------
module tb_i2c_master_bit_engine;
   import i2cmbe_pkg::*;

   localparam int SDA_LOW    = 0;
   localparam int SDA_HIGH   = 1;
   localparam int SDA_RANDOM = 2;
   localparam int RUN_LIMIT  = 1_000_000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = 16'd0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_cmd_valid = 1'b0;
   logic [1:0]  req_func = 2'd0;
   logic [7:0]  req_tx_byte = 8'h00;
   logic        req_send_ack = 1'b0;
   logic        req_sda_in = 1'b1;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_scl_out;
   logic        rsp_sda_out;
   logic        rsp_busy_res;
   logic        rsp_done_res;
   logic [7:0]  rsp_rx_byte;
   logic        rsp_ack_error;

   int   mismatches;
   int   pending_ticks;
   int   words_checked;
   int   sequences_done;
   logic quiet = 1'b0;
   int   half_now = 250;
   int   settings_used = 1;

   i2c_master_bit_engine i_dut (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_cmd_valid (req_cmd_valid),
      .req_func      (req_func),
      .req_tx_byte   (req_tx_byte),
      .req_send_ack  (req_send_ack),
      .req_sda_in    (req_sda_in),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_scl_out   (rsp_scl_out),
      .rsp_sda_out   (rsp_sda_out),
      .rsp_busy_res  (rsp_busy_res),
      .rsp_done_res  (rsp_done_res),
      .rsp_rx_byte   (rsp_rx_byte),
      .rsp_ack_error (rsp_ack_error)
   );

   i2c_bus_tick_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd_valid  (req_cmd_valid),
      .req_func       (req_func),
      .req_tx_byte    (req_tx_byte),
      .req_send_ack   (req_send_ack),
      .req_sda_in     (req_sda_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_scl_out    (rsp_scl_out),
      .rsp_sda_out    (rsp_sda_out),
      .rsp_busy_res   (rsp_busy_res),
      .rsp_done_res   (rsp_done_res),
      .rsp_rx_byte    (rsp_rx_byte),
      .rsp_ack_error  (rsp_ack_error),
      .mismatches     (mismatches),
      .pending_ticks  (pending_ticks),
      .words_checked  (words_checked),
      .sequences_done (sequences_done)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #RUN_LIMIT;
      $display("Run did not finish within the time limit.");
      $display("*** FAILED ***");
      $finish;
   end

   // Result side: a random stall before every result word unless quiet.
   initial begin : result_side
      int hold;
      while (reset) @(posedge clock);
      forever begin
         hold = quiet ? 0 : $urandom_range(0, 4);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // Returns at the edge that accepted the word.
   task automatic send_word(input logic cv, input logic [1:0] fn, input logic [7:0] tx,
                            input logic am, input logic sda);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_cmd_valid <= cv;
      req_func      <= fn;
      req_tx_byte   <= tx;
      req_send_ack  <= am;
      req_sda_in    <= sda;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Ticks with random fields; with pokes set, about one in four carries a
   // command, which starts a sequence only if the engine is idle.
   task automatic filler_ticks(input int n, input logic pokes);
      for (int i = 0; i < n; i++)
         send_word(pokes && $urandom_range(0, 3) == 0, 2'($urandom_range(0, 3)),
                   8'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
   endtask

   // One command followed by enough idle ticks for its whole sequence.
   // With poke set, a second command lands halfway and must be ignored.
   task automatic bus_command(input cmd_type op, input logic [7:0] tx, input logic am,
                              input int sda_mode, input logic poke);
      int   segs;
      int   ticks;
      logic sda;
      case (op)
         CMD_START: segs = 3;
         CMD_STOP:  segs = 4;
         CMD_WRITE: segs = 19;
         default:   segs = 20;
      endcase
      ticks = segs * ((half_now == 0) ? 1 : half_now);
      for (int i = 0; i < ticks + 2; i++) begin
         if (sda_mode == SDA_LOW) sda = 1'b0;
         else if (sda_mode == SDA_HIGH) sda = 1'b1;
         else sda = 1'($urandom_range(0, 1));
         if (i == 0)
            send_word(1'b1, op, tx, am, sda);
         else
            send_word(poke && i == ticks / 2, 2'($urandom_range(0, 3)), 8'($urandom),
                      1'($urandom_range(0, 1)), sda);
      end
   endtask

   // Random ticks, then idle ticks so the engine ends every sequence.
   task automatic random_ticks(input int n);
      int drain;
      drain = 20 * ((half_now == 0) ? 1 : half_now) + 2;
      filler_ticks(n, 1'b1);
      filler_ticks(drain, 1'b0);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_ticks != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_half_period(input logic [15:0] v);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      half_now = int'(v);
      settings_used++;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Reset value of the half period: the first segment of a start holds
      // for 250 ticks while ignored commands arrive, and the rest of the
      // sequence runs at one tick per segment.
      send_word(1'b1, CMD_START, 8'h00, 1'b0, 1'b1);
      filler_ticks(200, 1'b1);
      set_half_period(16'd1);
      filler_ticks(60, 1'b0);

      // A zero half period behaves as one tick.
      set_half_period(16'd0);
      bus_command(CMD_START, 8'h00, 1'b0, SDA_RANDOM, 1'b0);
      bus_command(CMD_WRITE, 8'hFF, 1'b0, SDA_HIGH, 1'b0);
      bus_command(CMD_WRITE, 8'h00, 1'b1, SDA_LOW, 1'b0);
      bus_command(CMD_READ, 8'h00, 1'b1, SDA_HIGH, 1'b0);
      bus_command(CMD_READ, 8'hFF, 1'b0, SDA_LOW, 1'b0);
      bus_command(CMD_WRITE, 8'hA5, 1'b0, SDA_RANDOM, 1'b1);
      bus_command(CMD_READ, 8'h00, 1'b1, SDA_RANDOM, 1'b1);
      bus_command(CMD_STOP, 8'h00, 1'b0, SDA_RANDOM, 1'b1);
      // Data phases with no start in front of them.
      bus_command(CMD_WRITE, 8'h5A, 1'b1, SDA_RANDOM, 1'b0);
      bus_command(CMD_READ, 8'h00, 1'b0, SDA_RANDOM, 1'b0);
      bus_command(CMD_START, 8'h00, 1'b1, SDA_RANDOM, 1'b1);
      bus_command(CMD_STOP, 8'h00, 1'b0, SDA_RANDOM, 1'b0);

      set_half_period(16'd1);
      random_ticks(40);
      set_half_period(16'd2);
      random_ticks(40);
      set_half_period(16'd3);
      random_ticks(40);
      set_half_period(16'($urandom_range(1, 5)));
      random_ticks(40);
      quiet = 1'b1;
      set_half_period(16'd1);
      random_ticks(40);

      // Widest half period: the first segment of a start outlasts the ticks
      // sent here, and a reset pulse ends the sequence.
      set_half_period(16'hFFFF);
      send_word(1'b1, CMD_START, 8'h00, 1'b0, 1'b1);
      filler_ticks(40, 1'b1);
      settle();
      reset <= 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      half_now = 250;
      repeat (4) @(posedge clock);
      quiet = 1'b0;

      $display("Run covered %0d result words and %0d completed bus sequences",
               words_checked, sequences_done);
      $display("over %0d half-period settings, including zero and the maximum.",
               settings_used);
      if (mismatches == 0 && pending_ticks == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

/* files.f */
hw/rtl/i2cmbe_pkg.sv
hw/rtl/i2cmbe_front.sv
hw/rtl/i2cmbe_engine.sv
hw/rtl/i2c_master_bit_engine.sv
hw/rtl/i2cmbe_checker.sv
bench/i2c_bus_tick_checker.sv
bench/tb_i2c_master_bit_engine.sv
